// ===== rtl/core/dbc_pkg.sv =====
// shared constants and register codes for the dalitz boundary check
// no dependencies; imported by every module of the block
package dbc_pkg;

    // default coordinate width, 20 fraction bits throughout (scale cancels)
    localparam int DEF_VALUE_WIDTH = 32;

    // configuration port geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // four parallel checks, seven registered stages per check, one output stage
    localparam int NUM_LANES   = 4;
    localparam int LANE_STAGES = 7;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    // check mode codes
    localparam logic FUNC_TWO   = 1'b0;
    localparam logic FUNC_THREE = 1'b1;

    // register index codes
    typedef enum logic [1:0] {
        REG_PARENT = 2'd0,
        REG_FIRST  = 2'd1,
        REG_SECOND = 2'd2,
        REG_THIRD  = 2'd3
    } t_reg_idx;

endpackage

// ===== rtl/core/dalitz_boundary_check.sv =====
// dalitz boundary check: one result word per accepted word, one word per cycle
// while the output is not stalled; four checks run in parallel lanes of 7 stages
// plus one output stage; a stalled result lets earlier stages keep filling
// synchronous active-low reset clears valid bits and the four mass registers
// depends on dbc_pkg, dbc_regs, dbc_lane
module dalitz_boundary_check import dbc_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_func,
    input  logic [VALUE_WIDTH-1:0] i_pair_one_two,
    input  logic [VALUE_WIDTH-1:0] i_pair_one_three,
    input  logic [VALUE_WIDTH-1:0] i_pair_two_three,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_inside_res
);

    localparam int VW = VALUE_WIDTH;

    logic [VW-1:0] m_sq, a_sq, b_sq, c_sq;

    dbc_regs #(.VALUE_WIDTH(VW)) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_parent (m_sq),
        .o_first  (a_sq),
        .o_second (b_sq),
        .o_third  (c_sq)
    );

    // pipeline control: a stage moves when empty or when the next one moves
    logic [PIPE_STAGES:1] r_vld;
    logic [PIPE_STAGES:1] en;
    logic [PIPE_STAGES:1] n_vld;

    always_comb begin
        en[PIPE_STAGES] = ~r_vld[PIPE_STAGES] | ~i_stall;
        for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign n_vld = {r_vld[PIPE_STAGES-1:1], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= PIPE_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_stall = ~en[1];
    assign o_valid = r_vld[PIPE_STAGES];

    // mass combinations and derived s23
    logic signed [VW+1:0] f1, f2, f3;
    logic signed [VW+2:0] s23_drv, s12_x, s13_x, s23_x;

    assign f1 = $signed({2'b00, m_sq}) + $signed({2'b00, a_sq})
              - $signed({2'b00, b_sq}) - $signed({2'b00, c_sq});
    assign f2 = $signed({2'b00, m_sq}) + $signed({2'b00, b_sq})
              - $signed({2'b00, a_sq}) - $signed({2'b00, c_sq});
    assign f3 = $signed({2'b00, m_sq}) + $signed({2'b00, c_sq})
              - $signed({2'b00, a_sq}) - $signed({2'b00, b_sq});
    assign s23_drv = $signed({3'b000, m_sq}) + $signed({3'b000, a_sq})
                   + $signed({3'b000, b_sq}) + $signed({3'b000, c_sq})
                   - $signed({3'b000, i_pair_one_two}) - $signed({3'b000, i_pair_one_three});
    assign s12_x = $signed({3'b000, i_pair_one_two});
    assign s13_x = $signed({3'b000, i_pair_one_three});
    assign s23_x = (i_func == FUNC_THREE) ? $signed({3'b000, i_pair_two_three}) : s23_drv;

    // lane operands: s12|s13, s13|s12, s23|s12, s23|s13
    logic [VW-1:0]        op_s  [NUM_LANES];
    logic signed [VW+2:0] op_x  [NUM_LANES];
    logic signed [VW+1:0] op_f  [NUM_LANES];
    logic [VW-1:0]        op_pa [NUM_LANES];
    logic [VW-1:0]        op_pb [NUM_LANES];
    logic [VW-1:0]        op_qa [NUM_LANES];
    logic [VW-1:0]        op_qb [NUM_LANES];
    logic [NUM_LANES-1:0] op_skip;
    logic [NUM_LANES-1:0] lane_ok;

    always_comb begin
        op_s[0] = i_pair_one_three; op_x[0] = s12_x; op_f[0] = f1;
        op_pa[0] = a_sq; op_pb[0] = c_sq; op_qa[0] = m_sq; op_qb[0] = b_sq;
        op_s[1] = i_pair_one_two;   op_x[1] = s13_x; op_f[1] = f1;
        op_pa[1] = a_sq; op_pb[1] = b_sq; op_qa[1] = m_sq; op_qb[1] = c_sq;
        op_s[2] = i_pair_one_two;   op_x[2] = s23_x; op_f[2] = f2;
        op_pa[2] = a_sq; op_pb[2] = b_sq; op_qa[2] = m_sq; op_qb[2] = c_sq;
        op_s[3] = i_pair_one_three; op_x[3] = s23_x; op_f[3] = f3;
        op_pa[3] = a_sq; op_pb[3] = c_sq; op_qa[3] = m_sq; op_qb[3] = b_sq;
        // two-coordinate mode needs only the middle two lanes
        op_skip = (i_func == FUNC_TWO) ? 4'b1001 : 4'b0000;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        dbc_lane #(.VALUE_WIDTH(VW)) u_lane (
            .i_clk  (i_clk),
            .i_en   (en[LANE_STAGES:1]),
            .i_skip (op_skip[g]),
            .i_s    (op_s[g]),
            .i_x    (op_x[g]),
            .i_f    (op_f[g]),
            .i_pa   (op_pa[g]),
            .i_pb   (op_pb[g]),
            .i_qa   (op_qa[g]),
            .i_qb   (op_qb[g]),
            .o_ok   (lane_ok[g])
        );
    end

    // output word register
    logic r_res;

    always_ff @(posedge i_clk) begin
        if (en[PIPE_STAGES]) begin
            r_res <= &lane_ok;
        end
    end

    assign o_inside_res = r_res;

    // checks
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a free stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[1])
        else $error("accepted word lost at stage one");

    a_last_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_STAGES-1] && en[PIPE_STAGES]) |=> o_valid)
        else $error("word lost at output stage");

endmodule

// ===== rtl/core/dbc_regs.sv =====
// configuration registers with apb access for the four squared masses
// depends on dbc_pkg
module dbc_regs import dbc_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output logic [VALUE_WIDTH-1:0] o_parent,
    output logic [VALUE_WIDTH-1:0] o_first,
    output logic [VALUE_WIDTH-1:0] o_second,
    output logic [VALUE_WIDTH-1:0] o_third
);

    logic [VALUE_WIDTH-1:0] r_parent, r_first, r_second, r_third;
    t_reg_idx               idx;
    logic                   wr_en;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parent <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_third  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_PARENT: r_parent <= VALUE_WIDTH'(pwdata);
                REG_FIRST:  r_first  <= VALUE_WIDTH'(pwdata);
                REG_SECOND: r_second <= VALUE_WIDTH'(pwdata);
                REG_THIRD:  r_third  <= VALUE_WIDTH'(pwdata);
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (idx)
            REG_PARENT: prdata = APB_DATA_W'(r_parent);
            REG_FIRST:  prdata = APB_DATA_W'(r_first);
            REG_SECOND: prdata = APB_DATA_W'(r_second);
            REG_THIRD:  prdata = APB_DATA_W'(r_third);
        endcase
    end

    assign o_parent = r_parent;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_third  = r_third;

endmodule

// ===== rtl/core/dbc_lane.sv =====
// one strict interval check lo(s) < x < hi(s) as a seven stage pipeline
// tests (F^2 - L1 - L2 - 4sx)^2 < 4 L1 L2 with exact integers; depends on dbc_pkg
module dbc_lane import dbc_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic [LANE_STAGES-1:0]        i_en,
    input  logic                          i_skip,
    input  logic [VALUE_WIDTH-1:0]        i_s,
    input  logic signed [VALUE_WIDTH+2:0] i_x,
    input  logic signed [VALUE_WIDTH+1:0] i_f,
    input  logic [VALUE_WIDTH-1:0]        i_pa,
    input  logic [VALUE_WIDTH-1:0]        i_pb,
    input  logic [VALUE_WIDTH-1:0]        i_qa,
    input  logic [VALUE_WIDTH-1:0]        i_qb,
    output logic                          o_ok
);

    localparam int VW  = VALUE_WIDTH;
    localparam int SW  = VW + 2;       // s - a - b
    localparam int XW  = VW + 3;       // coordinate under test
    localparam int QW  = 2 * VW + 4;   // squares
    localparam int PW  = 2 * VW;       // mass products
    localparam int SXW = 2 * VW + 6;   // s * x
    localparam int LW  = 2 * VW + 5;   // kallen value
    localparam int DW  = 2 * VW + 8;   // discriminant term
    localparam int MH  = DW / 2;       // half of |D|
    localparam int LH  = VW + 1;       // half of a kallen magnitude
    localparam int CW  = 4 * MH;       // compare width

    // stage 1: operands and s - a - b
    logic [VW-1:0]        r1_s, r1_pa, r1_pb, r1_qa, r1_qb;
    logic signed [XW-1:0] r1_x;
    logic signed [SW-1:0] r1_f, r1_t1, r1_t2;
    logic                 r1_skip;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_s    <= i_s;
            r1_x    <= i_x;
            r1_f    <= i_f;
            r1_pa   <= i_pa;
            r1_pb   <= i_pb;
            r1_qa   <= i_qa;
            r1_qb   <= i_qb;
            r1_t1   <= $signed({2'b00, i_s}) - $signed({2'b00, i_pa}) - $signed({2'b00, i_pb});
            r1_t2   <= $signed({2'b00, i_s}) - $signed({2'b00, i_qa}) - $signed({2'b00, i_qb});
            r1_skip <= i_skip;
        end
    end

    // stage 2: squares and products
    logic signed [QW-1:0]  r2_sq1, r2_sq2, r2_ff;
    logic [PW-1:0]         r2_pp1, r2_pp2;
    logic signed [SXW-1:0] r2_sx;
    logic                  r2_szero, r2_skip;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_sq1   <= r1_t1 * r1_t1;
            r2_sq2   <= r1_t2 * r1_t2;
            r2_ff    <= r1_f * r1_f;
            r2_pp1   <= r1_pa * r1_pb;
            r2_pp2   <= r1_qa * r1_qb;
            r2_sx    <= $signed({3'b000, r1_s}) * r1_x;
            r2_szero <= (r1_s == '0);
            r2_skip  <= r1_skip;
        end
    end

    // stage 3: kallen values (s-a-b)^2 - 4ab and 4sx
    logic signed [LW-1:0] r3_l1, r3_l2;
    logic signed [QW-1:0] r3_ff;
    logic signed [DW-1:0] r3_sx4;
    logic                 r3_bad, r3_skip;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_l1   <= LW'(r2_sq1) - $signed({3'b000, r2_pp1, 2'b00});
            r3_l2   <= LW'(r2_sq2) - $signed({3'b000, r2_pp2, 2'b00});
            r3_ff   <= r2_ff;
            r3_sx4  <= $signed({r2_sx, 2'b00});
            r3_bad  <= r2_szero;
            r3_skip <= r2_skip;
        end
    end

    // stage 4: discriminant term, reject negative kallen values
    logic signed [DW-1:0] r4_d;
    logic [2*LH-1:0]      r4_lm1, r4_lm2;
    logic                 r4_bad, r4_skip;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_d    <= DW'(r3_ff) - r3_sx4 - DW'(r3_l1) - DW'(r3_l2);
            r4_lm1  <= r3_l1[2*LH-1:0];
            r4_lm2  <= r3_l2[2*LH-1:0];
            r4_bad  <= r3_bad | r3_l1[LW-1] | r3_l2[LW-1];
            r4_skip <= r3_skip;
        end
    end

    // stage 5: magnitude of the discriminant term
    logic [DW-1:0]   r5_dm;
    logic [2*LH-1:0] r5_lm1, r5_lm2;
    logic            r5_bad, r5_skip;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_dm   <= r4_d[DW-1] ? (~r4_d + 1'b1) : r4_d;
            r5_lm1  <= r4_lm1;
            r5_lm2  <= r4_lm2;
            r5_bad  <= r4_bad;
            r5_skip <= r4_skip;
        end
    end

    // stage 6: half-word partial products
    logic [2*MH-1:0] r6_dhh, r6_dhl, r6_dll;
    logic [2*LH-1:0] r6_lhh, r6_lhl, r6_llh, r6_lll;
    logic            r6_bad, r6_skip;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r6_dhh  <= r5_dm[2*MH-1:MH] * r5_dm[2*MH-1:MH];
            r6_dhl  <= r5_dm[2*MH-1:MH] * r5_dm[MH-1:0];
            r6_dll  <= r5_dm[MH-1:0] * r5_dm[MH-1:0];
            r6_lhh  <= r5_lm1[2*LH-1:LH] * r5_lm2[2*LH-1:LH];
            r6_lhl  <= r5_lm1[2*LH-1:LH] * r5_lm2[LH-1:0];
            r6_llh  <= r5_lm1[LH-1:0] * r5_lm2[2*LH-1:LH];
            r6_lll  <= r5_lm1[LH-1:0] * r5_lm2[LH-1:0];
            r6_bad  <= r5_bad;
            r6_skip <= r5_skip;
        end
    end

    // stage 7: assemble D^2 and 4 L1 L2
    logic [CW-1:0] r7_lhs, r7_rhs;
    logic          r7_bad, r7_skip;

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r7_lhs  <= (CW'(r6_dhh) << (2 * MH)) + (CW'(r6_dhl) << (MH + 1)) + CW'(r6_dll);
            r7_rhs  <= ((CW'(r6_lhh) << (2 * LH)) + ((CW'(r6_lhl) + CW'(r6_llh)) << LH)
                       + CW'(r6_lll)) << 2;
            r7_bad  <= r6_bad;
            r7_skip <= r6_skip;
        end
    end

    assign o_ok = r7_skip | (~r7_bad & (r7_lhs < r7_rhs));

endmodule
